### design/lft_pkg.sv
// Shared types and constants for the LIN frame transmitter.
// Used by lft_front, lft_back and lin_frame_transmitter; depends on nothing.
`default_nettype none

package lft_pkg;

  // Largest number of data bytes in one frame.
  localparam int MaxDataBytes = 8;
  // Bits needed to index one data byte.
  localparam int IdxW = $clog2(MaxDataBytes);
  // Frame slots between the front and the back.
  localparam int QueueDepth = 2;
  localparam int QPtrW = $clog2(QueueDepth);

  localparam logic [7:0] SYNC_BYTE = 8'h55;

  // One frame request after the data count has been clamped.
  typedef struct packed {
    logic [7:0]                         id;
    logic [3:0]                         count;
    logic [MaxDataBytes-1:0][7:0]       data;
  } frame_t;

  // Position of the back end within the symbol run of one frame.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC,
    PH_ID,
    PH_DATA,
    PH_CSUM
  } phase_t;

endpackage

`default_nettype wire

### design/lin_frame_transmitter.sv
// Top level of the LIN frame transmitter with classic checksum.
// Depends on lft_pkg, lft_front and lft_back.
//
//   channel   handshake             payload
//   input     in_valid / in_stall   frame_id, data_count, data_byte_0..7
//   output    out_valid / out_stall symbol_byte, is_break, last_symbol
//
// A frame with n data bytes (count clamped to eight) gives 4 + n symbols,
// so up to 12 symbols, sent one per cycle by the back-end sequencer unless the output stalls.
// Frames follow one another without a gap cycle; a two-frame queue lets the
// input side keep transferring while a frame is still being sent.
// Output stall freezes the output register and the sequencer; input stall
// rises only when the queue is full. Reset empties the queue and output.
`default_nettype none

module lin_frame_transmitter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  frame_id,
  input  wire logic [3:0]  data_count,
  input  wire logic [7:0]  data_byte_0,
  input  wire logic [7:0]  data_byte_1,
  input  wire logic [7:0]  data_byte_2,
  input  wire logic [7:0]  data_byte_3,
  input  wire logic [7:0]  data_byte_4,
  input  wire logic [7:0]  data_byte_5,
  input  wire logic [7:0]  data_byte_6,
  input  wire logic [7:0]  data_byte_7,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       symbol_byte,
  output logic             is_break,
  output logic             last_symbol
);
  import lft_pkg::*;

  logic    q_valid;
  frame_t  q_frame;
  logic    pop;

  // Request intake and frame queue.
  lft_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .frame_id    (frame_id),
    .data_count  (data_count),
    .data_byte_0 (data_byte_0),
    .data_byte_1 (data_byte_1),
    .data_byte_2 (data_byte_2),
    .data_byte_3 (data_byte_3),
    .data_byte_4 (data_byte_4),
    .data_byte_5 (data_byte_5),
    .data_byte_6 (data_byte_6),
    .data_byte_7 (data_byte_7),
    .q_valid     (q_valid),
    .q_frame     (q_frame),
    .pop         (pop)
  );

  // Symbol sequencer and checksum.
  lft_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_frame     (q_frame),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol_byte (symbol_byte),
    .is_break    (is_break),
    .last_symbol (last_symbol)
  );

endmodule

`default_nettype wire

### design/lft_front.sv
// Front end: accepts frame requests, clamps the data count and queues them.
// Depends on lft_pkg for frame_t and the queue sizing constants.
`default_nettype none

module lft_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      frame_id,
  input  wire logic [3:0]      data_count,
  input  wire logic [7:0]      data_byte_0,
  input  wire logic [7:0]      data_byte_1,
  input  wire logic [7:0]      data_byte_2,
  input  wire logic [7:0]      data_byte_3,
  input  wire logic [7:0]      data_byte_4,
  input  wire logic [7:0]      data_byte_5,
  input  wire logic [7:0]      data_byte_6,
  input  wire logic [7:0]      data_byte_7,
  output logic                 q_valid,
  output lft_pkg::frame_t      q_frame,
  input  wire logic            pop
);
  import lft_pkg::*;

  frame_t               slots [QueueDepth];
  frame_t               incoming;
  logic [QPtrW-1:0]     wr_ptr;
  logic [QPtrW-1:0]     rd_ptr;
  logic [QPtrW:0]       level;
  logic                 accept;

  // Clamp the data count and gather the request into one frame word.
  always_comb begin
    incoming.id = frame_id;
    if (data_count > 4'(MaxDataBytes)) begin
      incoming.count = 4'(MaxDataBytes);
    end else begin
      incoming.count = data_count;
    end
    incoming.data = {data_byte_7, data_byte_6, data_byte_5, data_byte_4,
                     data_byte_3, data_byte_2, data_byte_1, data_byte_0};
  end

  // Handshake toward the sender and toward the back end.
  assign in_stall = (level == (QPtrW+1)'(QueueDepth));
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (level != '0);
  assign q_frame  = slots[rd_ptr];

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (accept && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !accept) begin
        level <= level - 1'b1;
      end
    end
  end

  // Queue slots hold payload only.
  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= incoming;
    end
  end

  // The back end never takes a frame from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("frame taken from an empty queue");

  // A queued frame always carries a clamped data count.
  a_count_clamped: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_frame.count <= 4'(MaxDataBytes)))
    else $error("queued data count above the maximum");

  // A transfer without a pop grows the queue by exactly one frame.
  a_level_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !pop) |=> (level == $past(level) + 1'b1))
    else $error("queue level did not follow a transfer");

endmodule

`default_nettype wire

### design/lft_back.sv
// Back end: walks one queued frame through break, sync, id, data and checksum.
// Depends on lft_pkg for frame_t, phase_t and the sync byte.
`default_nettype none

module lft_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire lft_pkg::frame_t q_frame,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           symbol_byte,
  output logic                 is_break,
  output logic                 last_symbol
);
  import lft_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  frame_t             cur;
  logic [IdxW-1:0]    idx;
  logic [7:0]         acc;
  logic [7:0]         acc_next;
  logic [8:0]         sum;
  logic               advance;
  logic               last_data;
  logic               emit;
  logic [7:0]         sym_byte;
  logic               sym_break;
  logic               sym_last;

  // The output register can take a new symbol when empty or being drained.
  assign advance   = !out_valid || !out_stall;
  assign pop       = advance && (phase == PH_IDLE) && q_valid;
  assign last_data = ((4'(idx) + 4'd1) == cur.count);

  // Running checksum: add with the carry folded back into bit 0.
  always_comb begin
    sum = {1'b0, acc} + {1'b0, cur.data[idx]};
    if (sum[8]) begin
      acc_next = sum[7:0] + 8'd1;
    end else begin
      acc_next = sum[7:0];
    end
  end

  // Next phase of the symbol run.
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (pop) phase_next = PH_SYNC;
      end
      PH_SYNC: begin
        if (advance) phase_next = PH_ID;
      end
      PH_ID: begin
        if (advance) phase_next = (cur.count == 4'd0) ? PH_CSUM : PH_DATA;
      end
      PH_DATA: begin
        if (advance && last_data) phase_next = PH_CSUM;
      end
      PH_CSUM: begin
        if (advance) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // Symbol produced in the current phase.
  always_comb begin
    emit      = advance;
    sym_byte  = 8'h00;
    sym_break = 1'b0;
    sym_last  = 1'b0;
    case (phase)
      PH_IDLE: begin
        emit      = pop;
        sym_break = 1'b1;
      end
      PH_SYNC: sym_byte = SYNC_BYTE;
      PH_ID:   sym_byte = cur.id;
      PH_DATA: sym_byte = cur.data[idx];
      PH_CSUM: begin
        sym_byte = ~acc;
        sym_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  // Frame, index, checksum and output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_frame;
      idx <= '0;
      acc <= 8'h00;
    end else if (advance && (phase == PH_DATA)) begin
      idx <= idx + 1'b1;
      acc <= acc_next;
    end
    if (advance && emit) begin
      symbol_byte <= sym_byte;
      is_break    <= sym_break;
      last_symbol <= sym_last;
    end
  end

  // A new frame is only taken between frames.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (phase == PH_IDLE))
    else $error("frame taken in the middle of a run");

  // The data index stays inside the frame's data count.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (4'(idx) < cur.count))
    else $error("data index past the data count");

  // Taking a frame always presents a break next.
  a_break_first: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && is_break && !last_symbol))
    else $error("frame did not open with a break");

endmodule

`default_nettype wire

### tb/sv/lin_frame_checker.sv
// Checker for the LIN frame transmitter: predicts the symbol run of each frame
// and compares it with the symbols the block sends.
// Depends on lft_pkg for the sync byte and the largest data count.
`timescale 1ns / 1ps

module lin_frame_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] frame_id,
  input  logic [3:0] data_count,
  input  logic [7:0] data_byte_0,
  input  logic [7:0] data_byte_1,
  input  logic [7:0] data_byte_2,
  input  logic [7:0] data_byte_3,
  input  logic [7:0] data_byte_4,
  input  logic [7:0] data_byte_5,
  input  logic [7:0] data_byte_6,
  input  logic [7:0] data_byte_7,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] symbol_byte,
  input  logic       is_break,
  input  logic       last_symbol,
  output int         fail_count,
  output int         pending
);
  import lft_pkg::*;

  // One symbol on the line side, as the block should present it.
  typedef struct packed {
    logic [7:0] sym;
    logic       brk;
    logic       last;
  } line_symbol_t;

  line_symbol_t expected_symbols[$];
  int           symbols_seen;

  // Classic checksum: end-around-carry sum of the data bytes, inverted.
  function automatic logic [7:0] classic_checksum(input logic [7:0][7:0] bytes,
                                                  input int n);
    logic [8:0] acc;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      acc = acc + {1'b0, bytes[k]};
      if (acc[8]) begin
        acc = {1'b0, acc[7:0]} + 9'd1;
      end
    end
    return ~acc[7:0];
  endfunction

  // Queues the whole symbol run of one frame request.
  function automatic void queue_frame_symbols(input logic [7:0] id,
                                              input logic [3:0] count,
                                              input logic [7:0][7:0] bytes);
    int n;
    n = (count > MaxDataBytes) ? MaxDataBytes : int'(count);
    expected_symbols.push_back('{sym: 8'h00, brk: 1'b1, last: 1'b0});
    expected_symbols.push_back('{sym: SYNC_BYTE, brk: 1'b0, last: 1'b0});
    expected_symbols.push_back('{sym: id, brk: 1'b0, last: 1'b0});
    for (int k = 0; k < n; k++) begin
      expected_symbols.push_back('{sym: bytes[k], brk: 1'b0, last: 1'b0});
    end
    expected_symbols.push_back('{sym: classic_checksum(bytes, n), brk: 1'b0,
                                 last: 1'b1});
  endfunction

  // Output transfers are checked before a new frame is queued, so a symbol
  // that shows up in the same cycle as its request is caught as unexpected.
  always @(posedge clk) begin
    line_symbol_t want;
    if (rst) begin
      expected_symbols.delete();
      fail_count   = 0;
      symbols_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_symbols.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected symbol byte %h break %b last %b", $time,
                   symbol_byte, is_break, last_symbol);
        end else begin
          want = expected_symbols.pop_front();
          if (symbol_byte !== want.sym || is_break !== want.brk ||
              last_symbol !== want.last) begin
            fail_count++;
            $display("%0t: symbol %0d expected byte %h break %b last %b, got %h %b %b",
                     $time, symbols_seen, want.sym, want.brk, want.last,
                     symbol_byte, is_break, last_symbol);
          end
        end
        symbols_seen++;
      end
      if (in_valid && !in_stall) begin
        queue_frame_symbols(frame_id, data_count,
                            {data_byte_7, data_byte_6, data_byte_5, data_byte_4,
                             data_byte_3, data_byte_2, data_byte_1, data_byte_0});
      end
    end
    pending = expected_symbols.size();
  end

endmodule

### tb/sv/tb_lin_frame_transmitter.sv
// Testbench top for the LIN frame transmitter: drives frame requests and
// output stalls, and reports the verdict. Depends on lin_frame_checker.
`timescale 1ns / 1ps

module tb_lin_frame_transmitter;

  localparam int CycleLimit = 400000;
  localparam int RandomFrames = 410;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] frame_id;
  logic [3:0] data_count;
  logic [7:0] data_byte_0, data_byte_1, data_byte_2, data_byte_3;
  logic [7:0] data_byte_4, data_byte_5, data_byte_6, data_byte_7;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] symbol_byte;
  logic       is_break;
  logic       last_symbol;

  int fail_count;
  int pending;
  int cycle_count;
  int stall_hold;
  int pick;

  lin_frame_transmitter u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .frame_id    (frame_id),
    .data_count  (data_count),
    .data_byte_0 (data_byte_0),
    .data_byte_1 (data_byte_1),
    .data_byte_2 (data_byte_2),
    .data_byte_3 (data_byte_3),
    .data_byte_4 (data_byte_4),
    .data_byte_5 (data_byte_5),
    .data_byte_6 (data_byte_6),
    .data_byte_7 (data_byte_7),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol_byte (symbol_byte),
    .is_break    (is_break),
    .last_symbol (last_symbol)
  );

  lin_frame_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .frame_id    (frame_id),
    .data_count  (data_count),
    .data_byte_0 (data_byte_0),
    .data_byte_1 (data_byte_1),
    .data_byte_2 (data_byte_2),
    .data_byte_3 (data_byte_3),
    .data_byte_4 (data_byte_4),
    .data_byte_5 (data_byte_5),
    .data_byte_6 (data_byte_6),
    .data_byte_7 (data_byte_7),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol_byte (symbol_byte),
    .is_break    (is_break),
    .last_symbol (last_symbol),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // 50 MHz clock.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output stall: mostly short runs either way, with some long free stretches
  // and some long stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold != 0) begin
      stall_hold--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(0, 3);
      end else if (pick < 85) begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else if (pick < 95) begin
        out_stall  <= 1'b0;
        stall_hold = $urandom_range(20, 60);
      end else begin
        out_stall  <= 1'b1;
        stall_hold = $urandom_range(10, 30);
      end
    end
  end

  function automatic logic [7:0][7:0] random_bytes();
    return {$urandom, $urandom};
  endfunction

  // Input gap length: usually none or short, now and then long.
  function automatic int input_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Presents one frame request and holds it until the transfer happens.
  // Inputs only change at the rising edge, so the stall seen at the falling
  // edge is the one sampled at the next rising edge.
  task automatic send_frame(input logic [7:0] id, input logic [3:0] count,
                            input logic [7:0][7:0] bytes);
    frame_id    <= id;
    data_count  <= count;
    data_byte_0 <= bytes[0];
    data_byte_1 <= bytes[1];
    data_byte_2 <= bytes[2];
    data_byte_3 <= bytes[3];
    data_byte_4 <= bytes[4];
    data_byte_5 <= bytes[5];
    data_byte_6 <= bytes[6];
    data_byte_7 <= bytes[7];
    in_valid    <= 1'b1;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // Sends a frame, then idles the input for a random gap.
  task automatic send_and_idle(input logic [7:0] id, input logic [3:0] count,
                               input logic [7:0][7:0] bytes);
    int gap;
    send_frame(id, count, bytes);
    gap = input_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [3:0]       count;
    logic [7:0][7:0]  bytes;
    int               r;
    cycle_count = 0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    out_stall   = 1'b0;
    frame_id    = '0;
    data_count  = '0;
    data_byte_0 = '0;
    data_byte_1 = '0;
    data_byte_2 = '0;
    data_byte_3 = '0;
    data_byte_4 = '0;
    data_byte_5 = '0;
    data_byte_6 = '0;
    data_byte_7 = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed frames: no data, identifier extremes, checksum carry cases,
    // full frames and counts above the maximum.
    send_and_idle(8'h00, 4'd0, '0);
    send_and_idle(8'hFF, 4'd0, {8{8'hFF}});
    send_and_idle(8'h55, 4'd1, '0);
    send_and_idle(8'hAA, 4'd1, {8{8'hFF}});
    send_and_idle(8'h3C, 4'd8, {8{8'hFF}});
    send_and_idle(8'hC3, 4'd8, '0);
    send_and_idle(8'h01, 4'd2, {48'h0, 8'h80, 8'h80});
    send_and_idle(8'h80, 4'd2, {48'h0, 8'hFF, 8'h01});
    send_and_idle(8'h7F, 4'd8, 64'h0807060504030201);
    send_and_idle(8'h5A, 4'd8, {4{8'h55, 8'hAA}});
    for (int c = 9; c <= 15; c++) begin
      send_and_idle(8'($urandom_range(0, 255)), c[3:0], random_bytes());
    end
    send_and_idle(8'hFF, 4'd15, {8{8'hFF}});
    for (int c = 3; c <= 7; c++) begin
      send_and_idle(8'($urandom_range(0, 255)), c[3:0], random_bytes());
    end

    // Random frames: mostly legal counts, some oversized, a few with
    // saturating data patterns to stress the carry fold.
    for (int i = 0; i < RandomFrames; i++) begin
      r = $urandom_range(0, 99);
      if (r < 88) begin
        count = 4'($urandom_range(0, 8));
      end else begin
        count = 4'($urandom_range(9, 15));
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        bytes = {8{8'hFF}};
      end else if (r < 7) begin
        bytes = {8{8'($urandom_range(128, 255))}};
      end else begin
        bytes = random_bytes();
      end
      send_and_idle(8'($urandom_range(0, 255)), count, bytes);
    end
    in_valid <= 1'b0;

    // Drain, then give stray symbols a chance to show up.
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
